FILE: hdl/bgelu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgelu_pkg
// Shared constants for the bias-add / GELU pipeline: fixed-point scale
// factors, internal datapath widths, register indexes and the erf and tanh
// sample tables.
// ----------------------------------------------------------------------------
package bgelu_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_TANH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_EN  = 1'b1;

  // Q.16 constants: 1/sqrt2, sqrt(2/pi), 0.044715*sqrt(2/pi)
  localparam logic [15:0] K_RSQRT2 = 16'd46341;
  localparam logic [15:0] K_B      = 16'd52290;
  localparam logic [11:0] K_C      = 12'd2338;

  // 1.0 in Q.15
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // Internal widths
  localparam int M_W     = 20;  // |v| clamped to 8.0, Q.16
  localparam int T_W     = 23;  // first product >> 16
  localparam int INNER_W = 18;  // C*s + B
  localparam int Z_W     = 21;  // table argument, Q.16
  localparam int R_W     = 14;  // interpolation fraction
  localparam int TAB_W   = 16;  // table entry, Q.15 unsigned
  localparam int TIDX_W  = 5;   // index into 17-entry table
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = DIFF_W + R_W + 1;
  localparam int GAIN_W  = 18;  // 1 + f, Q.15, 0..2.0

  typedef logic [TAB_W-1:0] tab_entry_t;

  // erf(z) and tanh(z) at z = k/4, k = 0..16
  localparam tab_entry_t ERF_TAB [0:16] = '{
    16'd0,     16'd9055,  16'd17056, 16'd23303, 16'd27614, 16'd30242,
    16'd31657, 16'd32331, 16'd32615, 16'd32720, 16'd32755, 16'd32765,
    16'd32767, 16'd32768, 16'd32768, 16'd32768, 16'd32768
  };

  localparam tab_entry_t TANH_TAB [0:16] = '{
    16'd0,     16'd8026,  16'd15143, 16'd20813, 16'd24956, 16'd27796,
    16'd29660, 16'd30847, 16'd31589, 16'd32048, 16'd32329, 16'd32500,
    16'd32606, 16'd32670, 16'd32708, 16'd32732, 16'd32746
  };

endpackage

FILE: hdl/bgelu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgelu_if
// Valid/ready channels: the input beat (activation, bias, last mark) and the
// result beat (result, last mark).
// ----------------------------------------------------------------------------
interface bgelu_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] activation;
  logic signed [DATA_WIDTH-1:0] bias_value;
  logic                         last_in;

  modport source (output valid, output activation, output bias_value, output last_in,
                  input ready);
  modport sink   (input valid, input activation, input bias_value, input last_in,
                  output ready);
endinterface

interface bgelu_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result;
  logic                         last_out;

  modport source (output valid, output result, output last_out, input ready);
  modport sink   (input valid, input result, input last_out, output ready);
endinterface

FILE: hdl/bgelu_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgelu_interp
// Table stage: reads the erf or tanh samples around the argument and forms
// the registered slope-times-fraction product for linear interpolation.
// ----------------------------------------------------------------------------
module bgelu_interp (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   use_tanh,
  input  logic [bgelu_pkg::Z_W-1:0]              z,
  output logic [bgelu_pkg::TAB_W-1:0]            base_r,
  output logic signed [bgelu_pkg::PROD_W-1:0]    slope_r,
  output logic                                   past_end_r
);

  logic [bgelu_pkg::TIDX_W-1:0]       idx;
  logic [bgelu_pkg::TIDX_W-1:0]       idx_hi;
  logic [bgelu_pkg::R_W-1:0]          frac;
  logic [bgelu_pkg::TAB_W-1:0]        t0;
  logic [bgelu_pkg::TAB_W-1:0]        t1;
  logic signed [bgelu_pkg::DIFF_W-1:0] diff;
  logic                               past_end;

  // z >= 4.0 (index 16 and up) means f = 1.0 exactly
  assign past_end = |z[bgelu_pkg::Z_W-1:bgelu_pkg::R_W+4];
  assign idx      = {1'b0, z[bgelu_pkg::R_W+3:bgelu_pkg::R_W]};
  assign idx_hi   = idx + 1'b1;
  assign frac     = z[bgelu_pkg::R_W-1:0];

  // Table read
  always_comb begin
    if (use_tanh) begin
      t0 = bgelu_pkg::TANH_TAB[idx];
      t1 = bgelu_pkg::TANH_TAB[idx_hi];
    end else begin
      t0 = bgelu_pkg::ERF_TAB[idx];
      t1 = bgelu_pkg::ERF_TAB[idx_hi];
    end
  end

  assign diff = $signed({1'b0, t1}) - $signed({1'b0, t0});

  // Slope times fraction, registered
  always_ff @(posedge clk) begin
    if (en) begin
      base_r     <= t0;
      slope_r    <= diff * $signed({1'b0, frac});
      past_end_r <= past_end;
    end
  end

endmodule

FILE: hdl/bias_add_gelu_activation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bias_add_gelu_activation
// Bias add with saturation, then GELU with erf or tanh form, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one beat per element: activation, bias_value, last_in.
//   out_if : one beat per element: result (GELU, saturated), last_out.
//   cfg_*  : single-cycle register write; use_tanh_approx (index 0, reset 0)
//            and bias_enable (index 1, reset 1). Write only while idle.
// Throughput: one beat per cycle, sustained while out_if.ready stays high.
//   Eight register stages (bias add, three argument multiplies, table read,
//   interpolation, scale, round); a result is valid on out_if once its beat
//   has passed through all of them into the round stage's output register.
// Stalls: each stage loads when it is empty or its successor moves, so a
//   stalled receiver first fills bubbles, then holds in_if.ready low; no
//   beat is dropped or repeated. The output register holds while stalled.
// Reset: synchronous, active low; clears all stage valids and loads the
//   register defaults. Payload registers are not reset.
// ----------------------------------------------------------------------------
module bias_add_gelu_activation #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bgelu_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic                               cfg_wdata,
  bgelu_in_if.sink                           in_if,
  bgelu_out_if.source                        out_if
);

  localparam int DW     = DATA_WIDTH;
  localparam int AW     = (DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4;
  localparam int P_W    = DATA_WIDTH + bgelu_pkg::GAIN_W;
  localparam int RND_W  = P_W - 16;
  localparam int NSTAGE = 8;
  localparam logic [AW-1:0] CAP = AW'(8) << FRAC_BITS;
  localparam logic signed [DW-1:0] SAT_HI = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_LO = {1'b1, {(DW-1){1'b0}}};

  // Configuration registers
  logic use_tanh_r;
  logic bias_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_tanh_r <= 1'b0;
      bias_en_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        bgelu_pkg::CFG_USE_TANH: use_tanh_r <= cfg_wdata;
        bgelu_pkg::CFG_BIAS_EN:  bias_en_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valids and advance chain; adv[k] loads stage k
  logic [NSTAGE:1] vld_r;
  logic [NSTAGE:1] adv;
  logic [NSTAGE:0] vld_in;

  assign vld_in = {vld_r[NSTAGE-1:1], in_if.valid};

  always_comb begin
    adv[NSTAGE] = !vld_r[NSTAGE] || out_if.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NSTAGE; k++) begin
        if (adv[k]) vld_r[k] <= vld_in[k-1];
      end
    end
  end

  assign in_if.ready = adv[1];

  // Values carried along the pipe
  logic signed [DW-1:0]            v_r    [1:6];
  logic                            neg_r  [1:5];
  logic                            last_r [1:8];
  logic [bgelu_pkg::M_W-1:0]       m_r    [1:3];

  always_ff @(posedge clk) begin
    if (adv[1]) last_r[1] <= in_if.last_in;
    for (int k = 2; k <= NSTAGE; k++) begin
      if (adv[k]) last_r[k] <= last_r[k-1];
    end
  end

  // Stage 1: bias add, saturate, magnitude clamp to 8.0, rescale to Q.16
  logic signed [DW:0]   sum1;
  logic signed [DW-1:0] v1;
  logic [DW-1:0]        mag1;
  logic [AW-1:0]        mag1_ext;
  logic [AW-1:0]        mcap1;
  logic [AW+15:0]       mq16;

  always_comb begin
    sum1 = {in_if.activation[DW-1], in_if.activation}
         + (bias_en_r ? {in_if.bias_value[DW-1], in_if.bias_value} : '0);
    if (sum1[DW] != sum1[DW-1]) begin
      v1 = sum1[DW] ? SAT_LO : SAT_HI;
    end else begin
      v1 = sum1[DW-1:0];
    end
    mag1     = v1[DW-1] ? DW'(-v1) : DW'(v1);
    mag1_ext = AW'(mag1);
    mcap1    = (mag1_ext > CAP) ? CAP : mag1_ext;
    mq16     = {mcap1, 16'b0} >> FRAC_BITS;
  end

  // Stage 1 load, then carried copies of v, sign and m
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      v_r[1]   <= v1;
      neg_r[1] <= v1[DW-1];
      m_r[1]   <= mq16[bgelu_pkg::M_W-1:0];
    end
    for (int k = 2; k <= 6; k++) begin
      if (adv[k]) v_r[k] <= v_r[k-1];
    end
    for (int k = 2; k <= 5; k++) begin
      if (adv[k]) neg_r[k] <= neg_r[k-1];
    end
    for (int k = 2; k <= 3; k++) begin
      if (adv[k]) m_r[k] <= m_r[k-1];
    end
  end

  // Stage 2: m/sqrt2 (exact) or m*m (approx)
  logic [35:0]               prod_rs2;
  logic [39:0]               prod_sq2;
  logic [bgelu_pkg::T_W-1:0] t_r;

  assign prod_rs2 = m_r[1] * bgelu_pkg::K_RSQRT2;
  assign prod_sq2 = m_r[1] * m_r[1];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      t_r <= use_tanh_r ? prod_sq2[38:16] : bgelu_pkg::T_W'(prod_rs2[35:16]);
    end
  end

  // Stage 3: inner term C*s + B (approx); exact argument passes through
  logic [34:0]               prod_c3;
  logic [19:0]               inner3;
  logic [bgelu_pkg::Z_W-1:0] arg_r;

  assign prod_c3 = bgelu_pkg::K_C * t_r;
  assign inner3  = 20'(prod_c3[34:16]) + 20'(bgelu_pkg::K_B);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      arg_r <= use_tanh_r ? bgelu_pkg::Z_W'(inner3[bgelu_pkg::INNER_W-1:0])
                          : t_r[bgelu_pkg::Z_W-1:0];
    end
  end

  // Stage 4: z = m*inner (approx) or pass through
  logic [37:0]               prod_z4;
  logic [bgelu_pkg::Z_W-1:0] z_r;

  assign prod_z4 = m_r[3] * arg_r[bgelu_pkg::INNER_W-1:0];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      z_r <= use_tanh_r ? prod_z4[36:16] : arg_r;
    end
  end

  // Stage 5: table read and slope product
  logic [bgelu_pkg::TAB_W-1:0]         base_r;
  logic signed [bgelu_pkg::PROD_W-1:0] slope_r;
  logic                                past_end_r;

  bgelu_interp u_interp (
    .clk        (clk),
    .en         (adv[5]),
    .use_tanh   (use_tanh_r),
    .z          (z_r),
    .base_r     (base_r),
    .slope_r    (slope_r),
    .past_end_r (past_end_r)
  );

  // Stage 6: f with sign, gain = 1 + f in Q.15
  logic signed [bgelu_pkg::GAIN_W:0]   f6;
  logic signed [bgelu_pkg::GAIN_W:0]   fs6;
  logic signed [bgelu_pkg::GAIN_W:0]   gain6;
  logic signed [bgelu_pkg::GAIN_W-1:0] gain_r;
  logic signed [bgelu_pkg::PROD_W-1:0] step6;

  always_comb begin
    step6 = slope_r >>> bgelu_pkg::R_W;
    if (past_end_r) begin
      f6 = $signed({3'b0, bgelu_pkg::ONE_Q15});
    end else begin
      f6 = $signed({3'b0, base_r}) + (bgelu_pkg::GAIN_W + 1)'(step6);
    end
    fs6   = neg_r[5] ? -f6 : f6;
    gain6 = $signed({3'b0, bgelu_pkg::ONE_Q15}) + fs6;
  end

  always_ff @(posedge clk) begin
    if (adv[6]) gain_r <= gain6[bgelu_pkg::GAIN_W-1:0];
  end

  // Stage 7: v * (1 + f)
  logic signed [P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (adv[7]) p_r <= v_r[6] * gain_r;
  end

  // Stage 8: round half up, saturate, output register
  logic signed [P_W-1:0]   prnd8;
  logic signed [RND_W-1:0] rnd8;
  logic signed [DW-1:0]    res8;
  logic signed [DW-1:0]    res_r;

  always_comb begin
    prnd8 = p_r + $signed(P_W'(1) << 15);
    rnd8  = RND_W'(prnd8 >>> 16);
    if (rnd8 > $signed(RND_W'(SAT_HI))) begin
      res8 = SAT_HI;
    end else if (rnd8 < $signed({{(RND_W-DW){1'b1}}, SAT_LO})) begin
      res8 = SAT_LO;
    end else begin
      res8 = rnd8[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) res_r <= res8;
  end

  assign out_if.valid    = vld_r[NSTAGE];
  assign out_if.result   = res_r;
  assign out_if.last_out = last_r[NSTAGE];

endmodule

FILE: hdl/bgelu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgelu_chk
// Port-level checks for bias_add_gelu_activation, bound to the top level.
// ----------------------------------------------------------------------------
module bgelu_chk #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 10
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] out_result,
  input logic                         out_last
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_last))
    else $error("result beat changed while stalled");

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  // Empty output register means the pipe moves, so input is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // GELU never goes below about -0.17; -0.5 bounds table error
  a_result_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> longint'(out_result) >= -(longint'(1) <<< (FRAC_BITS - 1)))
    else $error("result below GELU minimum");

endmodule

bind bias_add_gelu_activation bgelu_chk #(
  .DATA_WIDTH (DATA_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_bgelu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_result (out_if.result),
  .out_last   (out_if.last_out)
);
